>>> hw/rtl/cdei_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdei_pkg
// Shared types, codes and constants of the charge/diameter energy interpolator.
// ----------------------------------------------------------------------------
package cdei_pkg;

    // default store sizes
    localparam int MAX_DIAM_POINTS_DEF = 32;
    localparam int MAX_CHARGES_DEF     = 16;

    // carried index widths, wide enough for the largest store sizes
    localparam int DIDX_W = 8;
    localparam int CIDX_W = 6;

    // fraction bits
    localparam int FRAC_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAM_POINTS_1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAM_POINTS_2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_POINTS = 2'd2;

    // reset values of the count registers
    localparam logic [5:0] DIAM_POINTS_RST   = 6'd32;
    localparam logic [4:0] CHARGE_POINTS_RST = 5'd13;

    // command codes
    typedef enum logic [2:0] {
        CMD_LOAD_AX1 = 3'd0,
        CMD_LOAD_AX2 = 3'd1,
        CMD_LOAD_CHG = 3'd2,
        CMD_LOAD_TAB = 3'd3,
        CMD_QUERY    = 3'd4
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DIAM   = 2'd1,
        ST_CHARGE = 2'd2
    } t_status;

    // one accepted input item
    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  ci1;
        logic [3:0]  ci2;
        logic [4:0]  di1;
        logic [4:0]  di2;
        logic [31:0] dm1;
        logic [31:0] dm2;
        logic [6:0]  q1;
        logic [6:0]  q2;
        logic [31:0] bar;
        logic [31:0] wel;
    } t_item;

    // control and table data that travel down the pipeline
    typedef struct packed {
        logic              query;
        logic              tab_wr;
        t_status           status;
        logic [CIDX_W-1:0] c1;
        logic [CIDX_W-1:0] c2;
        logic [DIDX_W-1:0] d1;
        logic [DIDX_W-1:0] d2;
        logic [31:0]       bar;
        logic [31:0]       wel;
    } t_tag;

endpackage

>>> hw/rtl/cdei_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdei_in_if
// Input item channel: valid/ready handshake with load and query payload.
// ----------------------------------------------------------------------------
interface cdei_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        cmd;
    logic [3:0]        charge_index_1;
    logic [3:0]        charge_index_2;
    logic [4:0]        diam_index_1;
    logic [4:0]        diam_index_2;
    logic [31:0]       diameter_1;
    logic [31:0]       diameter_2;
    logic signed [6:0] charge_1;
    logic signed [6:0] charge_2;
    logic signed [31:0] barrier_in;
    logic signed [31:0] well_in;

    modport source (
        output valid, cmd, charge_index_1, charge_index_2, diam_index_1, diam_index_2,
               diameter_1, diameter_2, charge_1, charge_2, barrier_in, well_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, charge_index_1, charge_index_2, diam_index_1, diam_index_2,
               diameter_1, diameter_2, charge_1, charge_2, barrier_in, well_in,
        output ready
    );
endinterface

>>> hw/rtl/cdei_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdei_out_if
// Result channel: valid/ready handshake with status and both energies.
// ----------------------------------------------------------------------------
interface cdei_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] barrier_energy;
    logic signed [31:0] well_energy;

    modport source (output valid, status, barrier_energy, well_energy, input ready);
    modport sink   (input valid, status, barrier_energy, well_energy, output ready);
endinterface

>>> hw/rtl/charge_diameter_energy_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charge_diameter_energy_interpolator
// Table-driven bilinear interpolation of barrier and well energies over a
// charge pair and a diameter pair, with load commands for axes and tables.
//
// channel   dir  handshake     payload
// i_in      in   valid/ready   cmd, indexes, diameters, charges, table data
// o_out     out  valid/ready   status, barrier_energy, well_energy
// i_cfg_*   in   write enable  register index, data
//
// One item enters per cycle while no result is held. A query passes the
// input register, the search register, seventeen divider stages, the table
// read, five blend stages and the output register before it shows on o_out.
// Loads take the same path and give no result.
// A result waiting on o_out freezes the whole pipeline, i_in.ready included.
// Synchronous active-low reset clears valid bits and presets count registers
// only; axis, charge and table stores hold nothing defined until loaded.
// ----------------------------------------------------------------------------
module charge_diameter_energy_interpolator #(
    parameter int MAX_DIAM_POINTS = cdei_pkg::MAX_DIAM_POINTS_DEF,
    parameter int MAX_CHARGES     = cdei_pkg::MAX_CHARGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cdei_in_if.sink                            i_in,
    cdei_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [cdei_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cdei_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import cdei_pkg::*;

    logic [5:0]         r_dp1, r_dp2;
    logic [4:0]         r_cp;
    logic               w_en;
    t_item              w_item;

    logic               w_loc_v;
    t_tag               w_loc_tag;
    logic [31:0]        w_dm [2], w_prev [2], w_next [2];
    logic               w_div_v;
    t_tag               w_div_tag;
    logic [FRAC_W-1:0]  w_div_frac [2];
    logic               w_tab_v;
    t_tag               w_tab_tag;
    logic [FRAC_W-1:0]  w_tab_frac [2];
    logic [31:0]        w_bar_rd [4], w_wel_rd [4];
    logic               w_bl_v;
    t_status            w_bl_st;
    logic signed [31:0] w_bl_e [2];

    logic               r_out_valid;
    t_status            r_out_st;
    logic signed [31:0] r_out_bar, r_out_wel;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp1 <= DIAM_POINTS_RST;
            r_dp2 <= DIAM_POINTS_RST;
            r_cp  <= CHARGE_POINTS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIAM_POINTS_1: r_dp1 <= i_cfg_data;
                CFG_DIAM_POINTS_2: r_dp2 <= i_cfg_data;
                CFG_CHARGE_POINTS: r_cp  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless a result is held
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    assign w_item = '{
        cmd: i_in.cmd, ci1: i_in.charge_index_1, ci2: i_in.charge_index_2,
        di1: i_in.diam_index_1, di2: i_in.diam_index_2,
        dm1: i_in.diameter_1, dm2: i_in.diameter_2,
        q1: i_in.charge_1, q2: i_in.charge_2,
        bar: i_in.barrier_in, wel: i_in.well_in
    };

    cdei_locate #(
        .MAX_DIAM_POINTS (MAX_DIAM_POINTS),
        .MAX_CHARGES     (MAX_CHARGES)
    ) u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_item  (w_item),
        .i_dp1   (r_dp1),
        .i_dp2   (r_dp2),
        .i_cp    (r_cp),
        .o_valid (w_loc_v),
        .o_tag   (w_loc_tag),
        .o_dm    (w_dm),
        .o_prev  (w_prev),
        .o_next  (w_next)
    );

    cdei_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_loc_v),
        .i_tag   (w_loc_tag),
        .i_dm    (w_dm),
        .i_prev  (w_prev),
        .i_next  (w_next),
        .o_valid (w_div_v),
        .o_tag   (w_div_tag),
        .o_frac  (w_div_frac)
    );

    cdei_table #(
        .MAX_DIAM_POINTS (MAX_DIAM_POINTS),
        .MAX_CHARGES     (MAX_CHARGES)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_div_v),
        .i_tag    (w_div_tag),
        .i_frac   (w_div_frac),
        .o_valid  (w_tab_v),
        .o_tag    (w_tab_tag),
        .o_frac   (w_tab_frac),
        .o_bar_rd (w_bar_rd),
        .o_wel_rd (w_wel_rd)
    );

    cdei_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_tab_v),
        .i_tag    (w_tab_tag),
        .i_frac   (w_tab_frac),
        .i_bar_rd (w_bar_rd),
        .i_wel_rd (w_wel_rd),
        .o_valid  (w_bl_v),
        .o_status (w_bl_st),
        .o_energy (w_bl_e)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_bl_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_st  <= w_bl_st;
            r_out_bar <= w_bl_e[0];
            r_out_wel <= w_bl_e[1];
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_st;
    assign o_out.barrier_energy = r_out_bar;
    assign o_out.well_energy    = r_out_wel;

`ifndef SYNTHESIS
    // a held result blocks new transfers
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result held");

    // error results carry zero energies
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |->
        (o_out.barrier_energy == 32'sd0 && o_out.well_energy == 32'sd0))
        else $error("nonzero energy on error result");

    // a held result keeps its status and barrier energy until transferred
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=>
        (o_out.valid && $stable(o_out.status) && $stable(o_out.barrier_energy)))
        else $error("held result changed");
`endif

endmodule

>>> hw/rtl/cdei_locate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdei_locate
// Input stage, axis and charge stores, bracket search and charge lookup.
// ----------------------------------------------------------------------------
module cdei_locate #(
    parameter int MAX_DIAM_POINTS = 32,
    parameter int MAX_CHARGES     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  cdei_pkg::t_item    i_item,
    input  logic [5:0]         i_dp1,
    input  logic [5:0]         i_dp2,
    input  logic [4:0]         i_cp,
    output logic               o_valid,
    output cdei_pkg::t_tag     o_tag,
    output logic [31:0]        o_dm   [2],
    output logic [31:0]        o_prev [2],
    output logic [31:0]        o_next [2]
);
    import cdei_pkg::*;

    localparam int IW = (MAX_DIAM_POINTS > 2) ? $clog2(MAX_DIAM_POINTS) : 1;
    localparam int CW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;

    logic                      r_a_valid;
    t_item                     r_a_item;
    logic [31:0]               r_axis [2][MAX_DIAM_POINTS];
    logic [6:0]                r_chg  [MAX_CHARGES];

    int                        w_n    [2];
    int                        w_nc;
    logic [31:0]               w_dm   [2];
    logic [6:0]                w_q    [2];
    logic [MAX_DIAM_POINTS-1:0] w_gt    [2];
    logic [MAX_DIAM_POINTS-1:0] w_first [2];
    logic [IW-1:0]             w_lo   [2];
    logic [31:0]               w_prev [2];
    logic [31:0]               w_next [2];
    logic                      w_dok  [2];
    logic [MAX_CHARGES-1:0]    w_m     [2];
    logic [MAX_CHARGES-1:0]    w_mfirst[2];
    logic [CW-1:0]             w_pos  [2];
    logic                      w_cok  [2];
    logic                      w_di1_ok, w_di2_ok, w_ci1_ok, w_ci2_ok;
    t_tag                      w_tag;

    logic                      r_b_valid;
    t_tag                      r_b_tag;
    logic [31:0]               r_b_dm   [2];
    logic [31:0]               r_b_prev [2];
    logic [31:0]               r_b_next [2];

    function automatic int clamp_cnt(input int v, input int lo, input int hi);
        int r;
        r = v;
        if (v < lo) r = lo;
        if (v > hi) r = hi;
        return r;
    endfunction

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;
        end
    end

    // slot range checks
    assign w_di1_ok = 32'(r_a_item.di1) < 32'(MAX_DIAM_POINTS);
    assign w_di2_ok = 32'(r_a_item.di2) < 32'(MAX_DIAM_POINTS);
    assign w_ci1_ok = 32'(r_a_item.ci1) < 32'(MAX_CHARGES);
    assign w_ci2_ok = 32'(r_a_item.ci2) < 32'(MAX_CHARGES);

    // axis and charge list loads, in item order with the searches
    always_ff @(posedge i_clk) begin
        if (i_en && r_a_valid) begin
            if (r_a_item.cmd == CMD_LOAD_AX1 && w_di1_ok) begin
                r_axis[0][IW'(r_a_item.di1)] <= r_a_item.dm1;
            end
            if (r_a_item.cmd == CMD_LOAD_AX2 && w_di2_ok) begin
                r_axis[1][IW'(r_a_item.di2)] <= r_a_item.dm2;
            end
            if (r_a_item.cmd == CMD_LOAD_CHG && w_ci1_ok) begin
                r_chg[CW'(r_a_item.ci1)] <= r_a_item.q1;
            end
        end
    end

    // bracket search and charge lookup, one comparator per point
    always_comb begin
        w_n[0] = clamp_cnt(int'(i_dp1), 2, MAX_DIAM_POINTS);
        w_n[1] = clamp_cnt(int'(i_dp2), 2, MAX_DIAM_POINTS);
        w_nc   = clamp_cnt(int'(i_cp), 1, MAX_CHARGES);
        w_dm[0] = r_a_item.dm1;
        w_dm[1] = r_a_item.dm2;
        w_q[0]  = r_a_item.q1;
        w_q[1]  = r_a_item.q2;
        for (int k = 0; k < 2; k++) begin
            for (int j = 0; j < MAX_DIAM_POINTS; j++) begin
                w_gt[k][j] = (j < w_n[k]) && (r_axis[k][j] > w_dm[k]);
            end
            // lowest set bit: first point above the value
            w_first[k] = w_gt[k] & (~w_gt[k] + MAX_DIAM_POINTS'(1));
            w_lo[k]   = '0;
            w_prev[k] = '0;
            w_next[k] = '0;
            for (int j = 0; j < MAX_DIAM_POINTS; j++) begin
                if (w_first[k][j]) begin
                    w_next[k] = w_next[k] | r_axis[k][j];
                end
            end
            for (int j = 0; j < MAX_DIAM_POINTS - 1; j++) begin
                if (w_first[k][j+1]) begin
                    w_prev[k] = w_prev[k] | r_axis[k][j];
                    w_lo[k]   = w_lo[k] | IW'(j);
                end
            end
            w_dok[k] = (|w_gt[k]) && !w_first[k][0];

            for (int j = 0; j < MAX_CHARGES; j++) begin
                w_m[k][j] = (j < w_nc) && (r_chg[j] == w_q[k]);
            end
            w_mfirst[k] = w_m[k] & (~w_m[k] + MAX_CHARGES'(1));
            w_pos[k] = '0;
            for (int j = 0; j < MAX_CHARGES; j++) begin
                if (w_mfirst[k][j]) begin
                    w_pos[k] = w_pos[k] | CW'(j);
                end
            end
            w_cok[k] = |w_m[k];
        end
    end

    // tag for the rest of the pipeline
    always_comb begin
        w_tag        = '0;
        w_tag.status = ST_OK;
        w_tag.bar    = r_a_item.bar;
        w_tag.wel    = r_a_item.wel;
        if (r_a_item.cmd == CMD_QUERY) begin
            w_tag.query = 1'b1;
            w_tag.c1    = CIDX_W'(w_pos[0]);
            w_tag.c2    = CIDX_W'(w_pos[1]);
            w_tag.d1    = DIDX_W'(w_lo[0]);
            w_tag.d2    = DIDX_W'(w_lo[1]);
            if (!w_dok[0] || !w_dok[1]) begin
                w_tag.status = ST_DIAM;
            end else if (!w_cok[0] || !w_cok[1]) begin
                w_tag.status = ST_CHARGE;
            end
        end else if (r_a_item.cmd == CMD_LOAD_TAB) begin
            w_tag.tab_wr = w_di1_ok && w_di2_ok && w_ci1_ok && w_ci2_ok;
            w_tag.c1     = CIDX_W'(r_a_item.ci1);
            w_tag.c2     = CIDX_W'(r_a_item.ci2);
            w_tag.d1     = DIDX_W'(r_a_item.di1);
            w_tag.d2     = DIDX_W'(r_a_item.di2);
        end
    end

    // search result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_tag <= w_tag;
            for (int k = 0; k < 2; k++) begin
                r_b_dm[k]   <= w_dm[k];
                r_b_prev[k] <= w_prev[k];
                r_b_next[k] <= w_next[k];
            end
        end
    end

    assign o_valid = r_b_valid;
    assign o_tag   = r_b_tag;
    assign o_dm    = r_b_dm;
    assign o_prev  = r_b_prev;
    assign o_next  = r_b_next;

endmodule

>>> hw/rtl/cdei_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdei_divider
// Two-lane pipelined restoring divider: one fraction bit per stage.
// ----------------------------------------------------------------------------
module cdei_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  cdei_pkg::t_tag               i_tag,
    input  logic [31:0]                  i_dm   [2],
    input  logic [31:0]                  i_prev [2],
    input  logic [31:0]                  i_next [2],
    output logic                         o_valid,
    output cdei_pkg::t_tag               o_tag,
    output logic [cdei_pkg::FRAC_W-1:0]  o_frac [2]
);
    import cdei_pkg::*;

    localparam int NS = FRAC_W + 1;

    logic              r_v    [NS];
    t_tag              r_tag  [NS];
    logic [31:0]       r_rem  [NS][2];
    logic [31:0]       r_span [NS][2];
    logic [FRAC_W-1:0] r_quo  [NS][2];

    // offset into the bracket and bracket width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 0; k < 2; k++) begin
                r_rem[0][k]  <= i_dm[k] - i_prev[k];
                r_span[0][k] <= i_next[k] - i_prev[k];
                r_quo[0][k]  <= '0;
            end
        end
    end

    // one quotient bit per stage
    for (genvar s = 1; s < NS; s++) begin : g_step
        for (genvar k = 0; k < 2; k++) begin : g_lane
            logic [32:0] w_sh;
            logic        w_ge;

            assign w_sh = {r_rem[s-1][k], 1'b0};
            assign w_ge = w_sh >= {1'b0, r_span[s-1][k]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s][k]  <= w_ge ? 32'(w_sh - {1'b0, r_span[s-1][k]}) : w_sh[31:0];
                    r_span[s][k] <= r_span[s-1][k];
                    r_quo[s][k]  <= {r_quo[s-1][k][FRAC_W-2:0], w_ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    assign o_valid   = r_v[NS-1];
    assign o_tag     = r_tag[NS-1];
    assign o_frac[0] = r_quo[NS-1][0];
    assign o_frac[1] = r_quo[NS-1][1];

endmodule

>>> hw/rtl/cdei_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdei_table
// Energy tables in four banks split by diameter index parity, so the four
// corners of a query are read in the same cycle.
// ----------------------------------------------------------------------------
module cdei_table #(
    parameter int MAX_DIAM_POINTS = 32,
    parameter int MAX_CHARGES     = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  cdei_pkg::t_tag               i_tag,
    input  logic [cdei_pkg::FRAC_W-1:0]  i_frac [2],
    output logic                         o_valid,
    output cdei_pkg::t_tag               o_tag,
    output logic [cdei_pkg::FRAC_W-1:0]  o_frac [2],
    output logic [31:0]                  o_bar_rd [4],
    output logic [31:0]                  o_wel_rd [4]
);
    import cdei_pkg::*;

    localparam int IW    = (MAX_DIAM_POINTS > 2) ? $clog2(MAX_DIAM_POINTS) : 1;
    localparam int HW    = (IW > 1) ? IW - 1 : 1;
    localparam int CW    = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
    localparam int AW    = 2 * CW + 2 * HW;
    localparam int DEPTH = 2 ** AW;

    logic              r_valid;
    t_tag              r_tag;
    logic [FRAC_W-1:0] r_frac [2];
    logic [IW-1:0]     w_i1, w_i2;
    logic              w_go;

    assign w_i1 = IW'(i_tag.d1);
    assign w_i2 = IW'(i_tag.d2);
    assign w_go = i_en && i_valid;

    // bank b holds the entries whose first index parity is b[1], second b[0]
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] PB = 2'(b);

        logic [31:0]   r_bar_mem [DEPTH];
        logic [31:0]   r_wel_mem [DEPTH];
        logic [31:0]   r_bar_rd;
        logic [31:0]   r_wel_rd;
        logic [IW-1:0] w_x1, w_x2;
        logic [AW-1:0] w_addr;
        logic          w_we, w_re;

        // the corner index of this parity is the low index or the one above
        assign w_x1   = (w_i1[0] == PB[1]) ? w_i1 : w_i1 + IW'(1);
        assign w_x2   = (w_i2[0] == PB[0]) ? w_i2 : w_i2 + IW'(1);
        assign w_addr = {CW'(i_tag.c1), CW'(i_tag.c2), HW'(w_x1 >> 1), HW'(w_x2 >> 1)};
        assign w_we   = w_go && i_tag.tab_wr && (w_i1[0] == PB[1]) && (w_i2[0] == PB[0]);
        assign w_re   = w_go && i_tag.query && (i_tag.status == ST_OK);

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_bar_mem[w_addr] <= i_tag.bar;
                r_wel_mem[w_addr] <= i_tag.wel;
            end
            if (w_re) begin
                r_bar_rd <= r_bar_mem[w_addr];
                r_wel_rd <= r_wel_mem[w_addr];
            end
        end

        assign o_bar_rd[b] = r_bar_rd;
        assign o_wel_rd[b] = r_wel_rd;
    end

    // sideband alongside the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag  <= i_tag;
            r_frac <= i_frac;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_frac  = r_frac;

endmodule

>>> hw/rtl/cdei_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdei_blend
// Bilinear blend of the four corners for both energies, rounded to Q16.16.
// ----------------------------------------------------------------------------
module cdei_blend (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  cdei_pkg::t_tag               i_tag,
    input  logic [cdei_pkg::FRAC_W-1:0]  i_frac [2],
    input  logic [31:0]                  i_bar_rd [4],
    input  logic [31:0]                  i_wel_rd [4],
    output logic                         o_valid,
    output cdei_pkg::t_status            o_status,
    output logic signed [31:0]           o_energy [2]
);
    import cdei_pkg::*;

    // stage 0: corners in place
    logic               r0_v;
    t_status            r0_st;
    logic [FRAC_W-1:0]  r0_t [2];
    logic signed [31:0] r0_c [2][2][2];
    // stage 1: second-axis step times fraction
    logic               r1_v;
    t_status            r1_st;
    logic [FRAC_W-1:0]  r1_t1;
    logic signed [31:0] r1_c0 [2][2];
    logic signed [49:0] r1_p  [2][2];
    // stage 2: rows
    logic               r2_v;
    t_status            r2_st;
    logic [FRAC_W-1:0]  r2_t1;
    logic signed [49:0] r2_row [2][2];
    // stage 3: row difference
    logic               r3_v;
    t_status            r3_st;
    logic [FRAC_W-1:0]  r3_t1;
    logic signed [49:0] r3_row0 [2];
    logic signed [49:0] r3_diff [2];
    // stage 4: partial products of the first-axis step
    logic               r4_v;
    t_status            r4_st;
    logic signed [49:0] r4_row0 [2];
    logic signed [41:0] r4_hi [2];
    logic [40:0]        r4_lo [2];

    logic [31:0]        w_rd [2][4];
    logic [1:0]         w_par;
    logic [67:0]        w_sum [2];

    assign w_rd[0] = i_bar_rd;
    assign w_rd[1] = i_wel_rd;
    assign w_par   = {i_tag.d1[0], i_tag.d2[0]};

    // valid and status chain; loads end here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid && i_tag.query;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_st <= i_tag.status;
            r0_t  <= i_frac;
            r1_st <= r0_st;
            r1_t1 <= r0_t[0];
            r2_st <= r1_st;
            r2_t1 <= r1_t1;
            r3_st <= r2_st;
            r3_t1 <= r2_t1;
            r4_st <= r3_st;
            for (int l = 0; l < 2; l++) begin
                // corner (a,b) sits in the bank of parity (low index xor a, b)
                for (int a = 0; a < 2; a++) begin
                    for (int b = 0; b < 2; b++) begin
                        r0_c[l][a][b] <= $signed(w_rd[l][w_par ^ 2'({a[0], b[0]})]);
                    end
                end
                for (int a = 0; a < 2; a++) begin
                    r1_c0[l][a] <= r0_c[l][a][0];
                    r1_p[l][a]  <= (50'(r0_c[l][a][1]) - 50'(r0_c[l][a][0]))
                                   * 50'($signed({1'b0, r0_t[1]}));
                    r2_row[l][a] <= (50'(r1_c0[l][a]) <<< FRAC_W) + r1_p[l][a];
                end
                r3_row0[l] <= r2_row[l][0];
                r3_diff[l] <= r2_row[l][1] - r2_row[l][0];
                r4_row0[l] <= r3_row0[l];
                r4_hi[l]   <= 42'($signed(r3_diff[l][49:25])) * 42'($signed({1'b0, r3_t1}));
                r4_lo[l]   <= 41'(r3_diff[l][24:0]) * 41'(r3_t1);
            end
        end
    end

    // final sum with round half up, zero on error
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_sum[l] = (68'(r4_row0[l]) <<< FRAC_W) + (68'(r4_hi[l]) <<< 25)
                     + 68'(r4_lo[l]) + 68'h8000_0000;
            o_energy[l] = (r4_st == ST_OK) ? $signed(w_sum[l][63:32]) : 32'sd0;
        end
    end

    assign o_valid  = r4_v;
    assign o_status = r4_st;

endmodule

>>> dv/charge_diameter_energy_interpolator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charge_diameter_energy_interpolator_test
// Self-checking bench for the energy interpolator. Axes, charge list and
// table corners are loaded through the input channel, then queries are sent
// with random idling on both channels. A scoreboard predicts every query
// result from its own copy of the stores and compares status and energies.
// ----------------------------------------------------------------------------
module charge_diameter_energy_interpolator_test;
    import cdei_pkg::*;

    localparam int ND = MAX_DIAM_POINTS_DEF;
    localparam int NC = MAX_CHARGES_DEF;

    typedef struct {
        t_status            status;
        logic signed [31:0] bar;
        logic signed [31:0] wel;
    } t_energy;

    // bracket and charge positions of one query
    typedef struct {
        t_status     status;
        int          i1, i2, p1, p2;
        logic [15:0] t1, t2;
    } t_lookup;

    // ------------------------------------------------------------------------
    // scoreboard: mirror of the stores and queue of awaited energies
    // ------------------------------------------------------------------------
    class energy_scoreboard;
        logic [31:0] axis1 [ND];
        logic [31:0] axis2 [ND];
        logic [6:0]  charges [NC];
        logic [63:0] energy_store [int];
        logic [5:0]  pts1 = DIAM_POINTS_RST;
        logic [5:0]  pts2 = DIAM_POINTS_RST;
        logic [4:0]  npts = CHARGE_POINTS_RST;
        t_energy     awaited [$];
        int          errors, n_ok, n_diam, n_chg, n_loads;

        function int used_diam(logic [5:0] v);
            return (v < 2) ? 2 : (v > ND) ? ND : int'(v);
        endfunction

        function int used_chg();
            return (npts < 1) ? 1 : (npts > NC) ? NC : int'(npts);
        endfunction

        function int corner_key(int c1, int c2, int d1, int d2);
            return ((c1 * NC + c2) * ND + d1) * ND + d2;
        endfunction

        // first point above d, then fraction of the bracket
        function bit bracket(bit second, logic [31:0] d, output int lo,
                             output logic [15:0] frac);
            int          n, i;
            logic [31:0] prev, span;
            logic [47:0] num;
            n = used_diam(second ? pts2 : pts1);
            i = 0;
            lo = 0;
            frac = '0;
            while (i < n && (second ? axis2[i] : axis1[i]) <= d) i++;
            if (i == 0 || i >= n) return 0;
            prev = second ? axis2[i-1] : axis1[i-1];
            span = (second ? axis2[i] : axis1[i]) - prev;
            num  = {d - prev, 16'h0};
            num  = num / {16'h0, span};
            frac = num[15:0];
            lo   = i - 1;
            return 1;
        endfunction

        function bit find_charge(logic [6:0] q, output int pos);
            pos = 0;
            for (int i = 0; i < used_chg(); i++)
                if (charges[i] == q) begin
                    pos = i;
                    return 1;
                end
            return 0;
        endfunction

        function t_lookup lookup(t_item it);
            t_lookup r;
            r.status = ST_OK;
            if (!bracket(0, it.dm1, r.i1, r.t1) || !bracket(1, it.dm2, r.i2, r.t2))
                r.status = ST_DIAM;
            else if (!find_charge(it.q1, r.p1) || !find_charge(it.q2, r.p2))
                r.status = ST_CHARGE;
            return r;
        endfunction

        // weighted sum of four corners, rounded half up
        function logic [31:0] blend(t_lookup r, bit well);
            logic signed [65:0] acc;
            logic signed [31:0] e;
            longint             wa [2], wb [2];
            logic [63:0]        ent;
            acc = 0;
            wa[0] = 65536 - longint'(r.t1);
            wa[1] = longint'(r.t1);
            wb[0] = 65536 - longint'(r.t2);
            wb[1] = longint'(r.t2);
            for (int a = 0; a < 2; a++)
                for (int b = 0; b < 2; b++) begin
                    ent = energy_store[corner_key(r.p1, r.p2, r.i1 + a, r.i2 + b)];
                    e   = well ? ent[31:0] : ent[63:32];
                    acc += e * wa[a] * wb[b];
                end
            acc = acc + 66'sd2147483648;
            return acc[63:32];
        endfunction

        function void note_input(t_item it);
            t_lookup r;
            t_energy x;
            case (it.cmd)
                CMD_LOAD_AX1: axis1[it.di1] = it.dm1;
                CMD_LOAD_AX2: axis2[it.di2] = it.dm2;
                CMD_LOAD_CHG: charges[it.ci1] = it.q1;
                CMD_LOAD_TAB:
                    energy_store[corner_key(it.ci1, it.ci2, it.di1, it.di2)] =
                        {it.bar, it.wel};
                CMD_QUERY: begin
                    r = lookup(it);
                    x.status = r.status;
                    x.bar = 0;
                    x.wel = 0;
                    if (r.status == ST_OK) begin
                        x.bar = blend(r, 0);
                        x.wel = blend(r, 1);
                        n_ok++;
                    end else if (r.status == ST_DIAM) n_diam++;
                    else n_chg++;
                    awaited.push_back(x);
                    return;
                end
                default: ;
            endcase
            n_loads++;
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] bar, logic [31:0] wel);
            t_energy x;
            if (awaited.size() == 0) begin
                $error("result with nothing awaited: status %0d", st);
                errors++;
                return;
            end
            x = awaited.pop_front();
            if (st !== x.status) begin
                $error("status expected %0d actual %0d", x.status, st);
                errors++;
            end
            if (bar !== x.bar) begin
                $error("barrier_energy expected %h actual %h", x.bar, bar);
                errors++;
            end
            if (wel !== x.wel) begin
                $error("well_energy expected %h actual %h", x.wel, wel);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    calm;
    energy_scoreboard      sb;

    cdei_in_if  in_ch ();
    cdei_out_if out_ch ();

    charge_diameter_energy_interpolator dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // clock
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // overall limit
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // result side: random stalls, check every transfer
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.status, out_ch.barrier_energy, out_ch.well_energy);
            out_ch.ready <= calm || ($urandom_range(99) >= 30);
        end
    end

    function t_item random_item();
        t_item it;
        it.cmd = t_cmd'($urandom_range(4));
        {it.ci1, it.ci2, it.di1, it.di2} = $urandom;
        {it.q1, it.q2} = $urandom;
        it.dm1 = $urandom;
        it.dm2 = $urandom;
        it.bar = $urandom;
        it.wel = $urandom;
        return it;
    endfunction

    // one transfer on the input channel, caller sits on a clock edge
    task automatic send(t_item it);
        if (!calm && $urandom_range(99) < 30) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= it.cmd;
        in_ch.charge_index_1 <= it.ci1;
        in_ch.charge_index_2 <= it.ci2;
        in_ch.diam_index_1   <= it.di1;
        in_ch.diam_index_2   <= it.di2;
        in_ch.diameter_1     <= it.dm1;
        in_ch.diameter_2     <= it.dm2;
        in_ch.charge_1       <= it.q1;
        in_ch.charge_2       <= it.q2;
        in_ch.barrier_in     <= it.bar;
        in_ch.well_in        <= it.wel;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(it);
    endtask

    task automatic load_corner(int c1, int c2, int d1, int d2, bit fresh,
                               logic [31:0] bar, logic [31:0] wel);
        t_item it;
        if (!fresh && sb.energy_store.exists(sb.corner_key(c1, c2, d1, d2))) return;
        it = random_item();
        it.cmd = CMD_LOAD_TAB;
        it.ci1 = c1;
        it.ci2 = c2;
        it.di1 = d1;
        it.di2 = d2;
        if (fresh) begin
            it.bar = bar;
            it.wel = wel;
        end
        send(it);
    endtask

    // query whose corners are loaded first; extreme puts full-scale corners
    task automatic send_query(t_item it, int extreme);
        t_lookup r;
        it.cmd = CMD_QUERY;
        r = sb.lookup(it);
        if (r.status == ST_OK)
            for (int k = 0; k < 4; k++)
                load_corner(r.p1, r.p2, r.i1 + k / 2, r.i2 + k % 2, extreme != 0,
                            (extreme == 1) ? 32'h7fffffff : 32'h80000000,
                            (extreme == 1) ? 32'h80000000 : 32'h7fffffff);
        send(it);
    endtask

    // diameter somewhere inside a random bracket of the active axis
    function logic [31:0] inner_diam(bit second);
        int          i;
        logic [31:0] lo, hi;
        i  = $urandom_range(sb.used_diam(second ? sb.pts2 : sb.pts1) - 2);
        lo = second ? sb.axis2[i] : sb.axis1[i];
        hi = second ? sb.axis2[i+1] : sb.axis1[i+1];
        return (hi > lo) ? $urandom_range(hi - 1, lo) : $urandom;
    endfunction

    function t_item good_query();
        t_item it;
        it = random_item();
        it.dm1 = inner_diam(0);
        it.dm2 = inner_diam(1);
        it.q1  = sb.charges[$urandom_range(sb.used_chg() - 1)];
        it.q2  = sb.charges[$urandom_range(sb.used_chg() - 1)];
        return it;
    endfunction

    function logic [6:0] absent_charge();
        int dummy;
        for (int v = 0; v < 128; v++)
            if (!sb.find_charge(v[6:0], dummy)) return v[6:0];
        return 7'h0;
    endfunction

    // wait for all results plus the pipeline depth
    task automatic drain();
        int guard;
        in_ch.valid <= 1'b0;
        guard = 0;
        while (sb.awaited.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DIAM_POINTS_1: sb.pts1 = val;
            CFG_DIAM_POINTS_2: sb.pts2 = val;
            default:           sb.npts = val[4:0];
        endcase
    endtask

    task automatic load_axes(bit shuffle);
        t_item it;
        for (int i = 0; i < ND; i++) begin
            it = random_item();
            it.cmd = CMD_LOAD_AX1;
            it.di1 = i;
            it.dm1 = i * 32'h0780_0000 + 32'h100 + $urandom_range(32'h0700_0000);
            if (shuffle && $urandom_range(3) == 0) it.dm1 = $urandom;
            send(it);
            it.cmd = CMD_LOAD_AX2;
            it.di2 = i;
            it.dm2 = i * 32'h0780_0000 + 32'h100 + $urandom_range(32'h0700_0000);
            if (shuffle && $urandom_range(3) == 0) it.dm2 = $urandom;
            send(it);
        end
    endtask

    task automatic load_charges();
        t_item it;
        for (int i = 0; i < NC; i++) begin
            it = random_item();
            it.cmd = CMD_LOAD_CHG;
            it.ci1 = i;
            if (i == 0) it.q1 = 7'h40;
            if (i == 1) it.q1 = 7'h3f;
            send(it);
        end
    endtask

    // main sequence
    initial begin
        t_item       it;
        int          pick;
        logic [5:0]  pv1 [5] = '{6'd0, 6'd63, 6'd2, 6'd32, 6'd1};
        logic [5:0]  pv2 [5] = '{6'd63, 6'd2, 6'd0, 6'd1, 6'd32};
        logic [5:0]  pvc [5] = '{6'd31, 6'd1, 6'd0, 6'd16, 6'd20};

        sb = new();
        calm = 0;
        i_rst_n  <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_DIAM_POINTS_1;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        {in_ch.cmd, in_ch.charge_index_1, in_ch.charge_index_2} <= '0;
        {in_ch.diam_index_1, in_ch.diam_index_2} <= '0;
        {in_ch.diameter_1, in_ch.diameter_2, in_ch.charge_1, in_ch.charge_2} <= '0;
        {in_ch.barrier_in, in_ch.well_in} <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every axis slot and every charge slot before any query
        load_axes(0);
        load_charges();

        // directed: bracket edges, both error kinds, full-scale corners, unused codes
        it = good_query();
        it.dm1 = sb.axis1[0];
        it.dm2 = sb.axis2[ND - 2];
        send_query(it, 1);
        it = good_query();
        send_query(it, 2);
        it = good_query();
        it.dm1 = sb.axis1[5] + 1;
        send_query(it, 1);
        it = good_query();
        it.dm1 = 32'h0;
        send_query(it, 0);
        it = good_query();
        it.dm2 = 32'hffffffff;
        send_query(it, 0);
        it = good_query();
        it.dm1 = sb.axis1[ND - 1];
        send_query(it, 0);
        it = good_query();
        it.q1 = absent_charge();
        send_query(it, 0);
        it = good_query();
        it.q2 = absent_charge();
        send_query(it, 0);
        it = good_query();
        it.dm2 = 32'h0;
        it.q1 = absent_charge();
        send_query(it, 0);
        it = good_query();
        it.q1 = 7'h40;
        it.q2 = 7'h3f;
        send_query(it, 0);
        for (int c = 5; c < 8; c++) begin
            it = random_item();
            it.cmd = t_cmd'(c);
            send(it);
        end

        // random phases, each under new count settings
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_reg(CFG_DIAM_POINTS_1, (ph < 4) ? pv1[ph] : $urandom_range(63));
            write_reg(CFG_DIAM_POINTS_2, (ph < 4) ? pv2[ph] : $urandom_range(63));
            write_reg(CFG_CHARGE_POINTS, (ph < 4) ? pvc[ph] : $urandom_range(31));
            if (ph == 3) load_axes(1);
            calm = (ph == 2);
            for (int n = 0; n < 20; n++) begin
                pick = $urandom_range(99);
                if (pick < 70) send_query(good_query(), 0);
                else if (pick < 80) send_query(random_item(), 0);
                else if (pick < 88) begin
                    it = good_query();
                    if (pick < 84) it.q2 = absent_charge();
                    else it.dm1 = 32'hffffffff;
                    send_query(it, 0);
                end else if (pick < 94) begin
                    it = random_item();
                    it.cmd = t_cmd'($urandom_range(CMD_LOAD_TAB));
                    send(it);
                end else begin
                    it = random_item();
                    it.cmd = t_cmd'($urandom_range(7, 5));
                    send(it);
                end
            end
            calm = 0;
        end

        drain();
        if (sb.awaited.size() != 0) begin
            $display("status: fail");
            $finish;
        end
        $display("covered %0d good queries, %0d diameter errors, %0d charge errors",
                 sb.n_ok, sb.n_diam, sb.n_chg);
        $display("with %0d loads or unused codes over five count settings", sb.n_loads);
        if (sb.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
